// ----- rtl/core/pyd_pkg.sv -----
// ----------------------------------------------------------------------------
// pyd_pkg
// Shared types and character codes for the docstring line marker.
// ----------------------------------------------------------------------------
package pyd_pkg;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_SINGLE  = 2'd2,
        MODE_TRIPLE  = 2'd3
    } t_mode;

    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    localparam logic KIND_DQUOTE = 1'b0;
    localparam logic KIND_SQUOTE = 1'b1;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic       command;
        logic [7:0] text_byte;
    } t_item;

    function automatic logic [7:0] kind_char(input logic kind);
        return (kind == KIND_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
    endfunction

endpackage

// ----- rtl/core/pyd_if.sv -----
// ----------------------------------------------------------------------------
// pyd_in_if / pyd_out_if
// Valid/ready channels for source bytes and per-line results.
// ----------------------------------------------------------------------------
interface pyd_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] text_byte;

    modport source (output valid, output command, output text_byte, input ready);
    modport sink   (input valid, input command, input text_byte, output ready);
endinterface

interface pyd_out_if;
    logic valid;
    logic ready;
    logic line_in_docstring;
    logic open_after_line;

    modport source (output valid, output line_in_docstring, output open_after_line,
                    input ready);
    modport sink   (input valid, input line_in_docstring, input open_after_line,
                    output ready);
endinterface

// ----- rtl/core/python_docstring_line_marker_core.sv -----
// ----------------------------------------------------------------------------
// python_docstring_line_marker_core
// Python string/comment lexer that flags lines starting inside a docstring.
// ----------------------------------------------------------------------------
// Takes one byte or end-of-line transfer per cycle. Each transfer lands in an
// input register and is applied to the lexer state when the lexer takes it; an
// end-of-line gives its result from the result register, which follows the input
// register. The input stalls only while an end-of-line waits behind a result
// that has not been taken. Triple quotes are matched over a two-byte lookahead
// window, so a byte is resolved when the second byte after it arrives.
module python_docstring_line_marker_core
    import pyd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pyd_in_if.sink     i_in,
    pyd_out_if.source  o_out
);

    logic  w_valid;
    logic  w_take;
    t_item w_item;

    pyd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_valid),
        .o_item  (w_item),
        .i_take  (w_take)
    );

    pyd_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_item  (w_item),
        .o_take  (w_take),
        .o_out   (o_out)
    );

endmodule

// ----- rtl/core/pyd_in_stage.sv -----
// ----------------------------------------------------------------------------
// pyd_in_stage
// Input register: captures one transfer and holds it until the lexer takes it.
// ----------------------------------------------------------------------------
module pyd_in_stage
    import pyd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pyd_in_if.sink     i_in,
    output logic       o_valid,
    output t_item      o_item,
    input  logic       i_take
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    assign i_in.ready = !r_valid || i_take;
    assign w_load     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.command   <= i_in.command;
            r_item.text_byte <= i_in.text_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/core/pyd_lexer.sv -----
// ----------------------------------------------------------------------------
// pyd_lexer
// Lexical state, two-byte lookahead window and result register.
// ----------------------------------------------------------------------------
module pyd_lexer
    import pyd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_take,
    pyd_out_if.source  o_out
);

    localparam logic [1:0] SKIP_ONE   = 2'd1;
    localparam logic [1:0] SKIP_TWO   = 2'd2;
    localparam logic [1:0] SKIP_THREE = 2'd3;

    t_mode      r_mode,  n_mode;
    logic       r_tkind, n_tkind;
    logic       r_skind, n_skind;
    logic [1:0] r_cnt,   n_cnt;
    logic       r_began, n_began;
    logic [7:0] r_la [2];
    logic [7:0] n_la [2];
    logic       r_out_valid;
    logic       r_out_doc;
    logic       r_out_open;

    logic       w_eol;
    logic [1:0] w_skip;
    logic [7:0] w_c;
    logic [7:0] w_a;
    logic [7:0] w_b;
    logic [7:0] w_tq;

    assign w_eol  = (i_item.command == CMD_EOL);
    assign o_take = i_valid && (!w_eol || !r_out_valid || o_out.ready);

    assign w_c  = r_la[0];
    assign w_a  = r_la[1];
    assign w_b  = i_item.text_byte;
    assign w_tq = kind_char(r_tkind);

    always_comb begin
        n_mode  = r_mode;
        n_tkind = r_tkind;
        n_skind = r_skind;
        n_cnt   = r_cnt;
        n_began = r_began;
        n_la[0] = r_la[0];
        n_la[1] = r_la[1];
        w_skip  = SKIP_ONE;

        case (r_mode)
            MODE_TRIPLE: begin
                if (w_c == w_tq && w_a == w_tq && w_b == w_tq) begin
                    n_mode = MODE_PLAIN;
                    w_skip = SKIP_THREE;
                end
            end
            MODE_COMMENT: begin
                w_skip = SKIP_ONE;
            end
            MODE_SINGLE: begin
                if (w_c == CH_BSLASH) begin
                    w_skip = SKIP_TWO;
                end else if (w_c == kind_char(r_skind)) begin
                    n_mode = MODE_PLAIN;
                end
            end
            default: begin
                if (w_c == CH_HASH) begin
                    n_mode = MODE_COMMENT;
                end else if (w_c == CH_DQUOTE || w_c == CH_SQUOTE) begin
                    if (w_a == w_c && w_b == w_c) begin
                        n_mode  = MODE_TRIPLE;
                        n_tkind = (w_c == CH_SQUOTE);
                        w_skip  = SKIP_THREE;
                    end else begin
                        n_mode  = MODE_SINGLE;
                        n_skind = (w_c == CH_SQUOTE);
                    end
                end
            end
        endcase

        if (w_eol) begin
            // flushed bytes can neither open nor close a triple-quoted string
            n_mode  = (r_mode == MODE_TRIPLE) ? MODE_TRIPLE : MODE_PLAIN;
            n_tkind = r_tkind;
            n_skind = r_skind;
            n_began = (r_mode == MODE_TRIPLE);
            n_cnt   = 2'd0;
        end else if (r_cnt != 2'd2) begin
            n_mode        = r_mode;
            n_tkind       = r_tkind;
            n_skind       = r_skind;
            n_la[r_cnt[0]] = w_b;
            n_cnt         = r_cnt + 2'd1;
        end else begin
            case (w_skip)
                SKIP_ONE: begin
                    n_la[0] = w_a;
                    n_la[1] = w_b;
                    n_cnt   = 2'd2;
                end
                SKIP_TWO: begin
                    n_la[0] = w_b;
                    n_cnt   = 2'd1;
                end
                default: begin
                    n_cnt = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PLAIN;
            r_tkind <= KIND_DQUOTE;
            r_skind <= KIND_DQUOTE;
            r_cnt   <= 2'd0;
            r_began <= 1'b0;
        end else if (o_take) begin
            r_mode  <= n_mode;
            r_tkind <= n_tkind;
            r_skind <= n_skind;
            r_cnt   <= n_cnt;
            r_began <= n_began;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_la[0] <= n_la[0];
            r_la[1] <= n_la[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && w_eol) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && w_eol) begin
            r_out_doc  <= r_began;
            r_out_open <= (r_mode == MODE_TRIPLE);
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.line_in_docstring = r_out_doc;
    assign o_out.open_after_line   = r_out_open;

endmodule

// ----- rtl/core/pyd_checker.sv -----
// ----------------------------------------------------------------------------
// pyd_checker
// Port-level checks on the docstring line marker.
// ----------------------------------------------------------------------------
module pyd_checker
    import pyd_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_command,
    input logic i_out_valid,
    input logic i_out_ready
);

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    // stall input only behind a pending result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

    // no result straight out of reset
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

    // a text byte transfer into an idle block gives no result
    a_text_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_command == CMD_TEXT && !i_out_valid
        && $past(!(i_in_valid && i_in_ready && i_in_command == CMD_EOL))
        |=> !i_out_valid ##1 !i_out_valid)
        else $error("result without end of line");

endmodule

bind python_docstring_line_marker_core pyd_checker u_pyd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_command (i_in.command),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready)
);
